// ===== src/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

   // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Conversion constants
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;

   // Byte positions within one frame
   typedef enum logic [2:0] {
      POS_TEMP_MSB = 3'd0,
      POS_TEMP_LSB = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_MSB  = 3'd3,
      POS_HUM_LSB  = 3'd4,
      POS_HUM_CRC  = 3'd5
   } pos_type;

   // Result status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   // One complete frame handed from the assembler to the scaler
   typedef struct packed {
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      logic        status;
   } frame_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/htfd_assembler.sv =====
// ----------------------------------------------------------------------------
// htfd_assembler
// Tracks the byte position, runs the CRC and assembles the two raw words.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_assembler (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   input  wire logic               frame_start,
   output logic                    frame_valid,
   output htfd_pkg::frame_type     frame
);

   htfd_pkg::pos_type pos_ff, pos_in, eff_pos;
   logic [7:0]        crc_ff, crc_in;
   logic [15:0]       temp_hold_ff, temp_hold_in;
   logic [15:0]       hum_hold_ff, hum_hold_in;
   logic              temp_good_ff, temp_good_in;
   logic [7:0]        crc_upd;

   // frame_start, or an unused position code, restarts at the first byte
   assign eff_pos = (frame_start || (pos_ff > htfd_pkg::POS_HUM_CRC)) ?
                    htfd_pkg::POS_TEMP_MSB : pos_ff;

   assign crc_upd = htfd_pkg::crc8_byte(
                       (eff_pos == htfd_pkg::POS_TEMP_MSB ||
                        eff_pos == htfd_pkg::POS_HUM_MSB) ? htfd_pkg::CRC_INIT : crc_ff,
                       data_byte);

   always_comb begin
      crc_in       = crc_ff;
      temp_hold_in = temp_hold_ff;
      hum_hold_in  = hum_hold_ff;
      temp_good_in = temp_good_ff;
      pos_in       = htfd_pkg::pos_type'(eff_pos + 3'd1);
      case (eff_pos)
         htfd_pkg::POS_TEMP_MSB: begin
            temp_hold_in = {data_byte, 8'h00};
            crc_in       = crc_upd;
         end
         htfd_pkg::POS_TEMP_LSB: begin
            temp_hold_in = {temp_hold_ff[15:8], data_byte};
            crc_in       = crc_upd;
         end
         htfd_pkg::POS_TEMP_CRC: begin
            temp_good_in = (crc_ff == data_byte);
            crc_in       = htfd_pkg::CRC_INIT;
         end
         htfd_pkg::POS_HUM_MSB: begin
            hum_hold_in = {data_byte, 8'h00};
            crc_in      = crc_upd;
         end
         htfd_pkg::POS_HUM_LSB: begin
            hum_hold_in = {hum_hold_ff[15:8], data_byte};
            crc_in      = crc_upd;
         end
         htfd_pkg::POS_HUM_CRC: begin
            crc_in = htfd_pkg::CRC_INIT;
            pos_in = htfd_pkg::POS_TEMP_MSB;
         end
         default: begin
            pos_in = htfd_pkg::POS_TEMP_MSB;
         end
      endcase
   end

   assign frame_valid     = accept && (eff_pos == htfd_pkg::POS_HUM_CRC);
   assign frame.temp_word = temp_hold_ff;
   assign frame.hum_word  = hum_hold_ff;
   assign frame.status    = (temp_good_ff && (crc_ff == data_byte)) ?
                            htfd_pkg::STATUS_OK : htfd_pkg::STATUS_CRC_ERR;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= htfd_pkg::POS_TEMP_MSB;
         crc_ff       <= htfd_pkg::CRC_INIT;
         temp_good_ff <= 1'b0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_good_ff <= temp_good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         temp_hold_ff <= temp_hold_in;
         hum_hold_ff  <= hum_hold_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/htfd_scaler.sv =====
// ----------------------------------------------------------------------------
// htfd_scaler
// Two-stage conversion pipeline: multiply by span, then divide by 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_scaler (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                frame_valid,
   input  wire htfd_pkg::frame_type frame,
   output logic                     frame_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [14:0]       rsp_temperature_centi,
   output logic [13:0]              rsp_humidity_centi,
   output logic [15:0]              rsp_temp_word,
   output logic [15:0]              rsp_humidity_word,
   output logic                     rsp_status
);

   logic                s1_valid_ff;
   htfd_pkg::frame_type s1_frame_ff;
   logic [30:0]         temp_prod_ff, temp_prod_in;
   logic [29:0]         hum_prod_ff, hum_prod_in;
   logic                s1_move;
   logic                rsp_valid_ff;
   logic [31:0]         temp_sum;
   logic [30:0]         hum_sum;
   logic [14:0]         temp_q;
   logic [13:0]         hum_q;
   logic [14:0]         temp_centi_ff, temp_centi_in;
   logic [13:0]         hum_centi_ff, hum_centi_in;
   htfd_pkg::frame_type out_frame_ff;

   // advance stage 1 into the result register when it is empty or drained
   assign s1_move     = !rsp_valid_ff || rsp_ready;
   assign frame_ready = !s1_valid_ff || s1_move;

   assign temp_prod_in = 31'(htfd_pkg::TEMP_SPAN) * 31'(frame.temp_word);
   assign hum_prod_in  = 30'(htfd_pkg::HUM_SPAN) * 30'(frame.hum_word);

   // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 65535 * 65535
   assign temp_sum      = 32'(temp_prod_ff) + 32'(temp_prod_ff[30:16]) + 32'd1;
   assign hum_sum       = 31'(hum_prod_ff) + 31'(hum_prod_ff[29:16]) + 31'd1;
   assign temp_q        = temp_sum[30:16];
   assign hum_q         = hum_sum[29:16];
   assign temp_centi_in = temp_q - htfd_pkg::TEMP_OFFSET;
   assign hum_centi_in  = hum_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (frame_ready) begin
            s1_valid_ff <= frame_valid;
         end
         if (s1_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_ready && frame_valid) begin
         s1_frame_ff  <= frame;
         temp_prod_ff <= temp_prod_in;
         hum_prod_ff  <= hum_prod_in;
      end
      if (s1_move && s1_valid_ff) begin
         out_frame_ff  <= s1_frame_ff;
         temp_centi_ff <= temp_centi_in;
         hum_centi_ff  <= hum_centi_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = $signed(temp_centi_ff);
   assign rsp_humidity_centi    = hum_centi_ff;
   assign rsp_temp_word         = out_frame_ff.temp_word;
   assign rsp_humidity_word     = out_frame_ff.hum_word;
   assign rsp_status            = out_frame_ff.status;

endmodule

`default_nettype wire

// ===== src/humidity_temp_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes the six-byte humidity/temperature sensor frame into scaled values.
// ----------------------------------------------------------------------------
// Bytes arrive one item per cycle while req_ready is high: temperature MSB,
// LSB, CRC, then humidity MSB, LSB, CRC. Each word is checked with CRC-8
// (poly 0x31, init 0xFF, no final xor). The sixth byte produces one
// result item carrying temperature in hundredths of a degree C
// (floor(17500*raw/65535) - 4500), humidity in hundredths of a percent
// (floor(10000*raw/65535)), both raw words and a status bit (0 ok, 1 CRC
// mismatch in either word; the values are still given). req_frame_start
// marks the first byte of a frame and drops any partial frame. A byte item
// is accepted every cycle that req_ready is high; the result passes through
// the multiply stage and then the divide-by-65535 stage. Back-pressure on
// the rsp side holds req_ready low only once both pipeline stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_data_byte,
   input  wire logic          req_frame_start,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [15:0]        rsp_temp_word,
   output logic [15:0]        rsp_humidity_word,
   output logic               rsp_status
);

   logic                req_accept;
   logic                frame_valid;
   logic                frame_ready;
   htfd_pkg::frame_type frame;

   // take a byte only when the conversion pipeline can absorb a frame end
   assign req_ready  = frame_ready;
   assign req_accept = req_valid && req_ready;

   // byte position, CRC and word assembly
   htfd_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   // scaling pipeline and result register
   htfd_scaler u_scaler (
      .clock                 (clock),
      .reset                 (reset),
      .frame_valid           (frame_valid),
      .frame                 (frame),
      .frame_ready           (frame_ready),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temp_word         (rsp_temp_word),
      .rsp_humidity_word     (rsp_humidity_word),
      .rsp_status            (rsp_status)
   );

   // input stalls only while a result is held by the rsp side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without rsp back-pressure");

   // humidity never exceeds full scale
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity_centi <= 14'd10000))
      else $error("humidity result above full scale");

   // temperature stays within the sensor span
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_temperature_centi >= -15'sd4500) &&
                     (rsp_temperature_centi <= 15'sd13000)))
      else $error("temperature result out of span");

endmodule

`default_nettype wire
